@@ rtl/aapb_pkg.sv @@
// ----------------------------------------------------------------------------
// Anti-aliased pixel blend package
// Beat types, register indexes and sequencer states shared by the blend unit.
// ----------------------------------------------------------------------------
package aapb_pkg;

  localparam int POS_W      = 12;
  localparam int ALPHA_W    = 9;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_ANTIALIAS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BG_COLOR  = 2'd3;

  // Red in the top byte, blue in the bottom byte, as in the frame store.
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [ALPHA_W-1:0] alpha;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_BLEND
  } state_e;

endpackage

@@ rtl/antialiased_pixel_blend_unit.sv @@
// ----------------------------------------------------------------------------
// Anti-aliased pixel blend unit
// Splats sub-pixel points into an RGB888 frame store and emits every pixel
// blended into it.
// ----------------------------------------------------------------------------
// Each input beat is a point with FRAC_BITS fraction bits and an RGBA color.
// With anti-aliasing on it is blended into up to four neighbor pixels with
// bilinear weights; with it off, into the nearest pixel. Every visible pixel
// is read from the single-port frame memory, blended and written back, and
// goes out as one output beat; last marks the final beat of a point. Each
// visible pixel is addressed, read, blended and written back on the one
// memory port, waiting while the output is stalled; no new beat is taken
// until the point is done. After reset and after every write of the
// background color all MAX_WIDTH*MAX_HEIGHT words (65536 by default) are
// filled, one word per cycle; no point is taken meanwhile.
// ----------------------------------------------------------------------------
module antialiased_pixel_blend_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  aapb_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output aapb_pkg::out_beat_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [aapb_pkg::CFG_ADDR_W-1:0]     cfg_index_i,
  input  logic [aapb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAW   = $clog2(DEPTH);
  localparam int PW    = aapb_pkg::POS_W;
  localparam int CW    = PW + 1 - FRAC_BITS;
  localparam int WW    = FRAC_BITS + 1;
  localparam int W2W   = 2 * FRAC_BITS + 1;
  localparam int AW    = 2 * FRAC_BITS + 9;
  localparam int CMPW  = 14;
  localparam logic [WW-1:0]  ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW:0]    HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [MAW-1:0] LAST_ADDR = MAW'(DEPTH - 1);

  function automatic logic in_view(input logic [CW-1:0] pos, input logic [8:0] lim,
                                   input logic [CMPW-1:0] max_lim);
    return (CMPW'(pos) < CMPW'(lim)) && (CMPW'(pos) < max_lim);
  endfunction

  // Configuration registers.
  logic                 aa_en_q;
  logic [8:0]           disp_w_q;
  logic [8:0]           disp_h_q;
  logic [23:0]          bg_q;
  logic                 bg_write;

  aapb_pkg::state_e     state_q, state_d;
  logic [MAW-1:0]       fill_cnt_q;
  logic [3:0]           mask_q;
  logic                 out_valid_q;
  aapb_pkg::out_beat_t  out_q;

  // Point setup.
  logic                 in_accept;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 fx_nz, fy_nz;
  logic [CW-1:0]        ax0, ax1, ay0, ay1, rx, ry;
  logic [PW:0]          x_sum, y_sum;
  logic [WW-1:0]        awx0, awx1, awy0, awy1;
  logic [3:0]           mask_in;
  logic [8:0]           alpha_sat;

  logic [CW-1:0]        x0_q, x1_q, y0_q, y1_q;
  logic [WW-1:0]        wx0_q, wx1_q, wy0_q, wy1_q;
  logic [8:0]           alpha_q;
  aapb_pkg::rgb_t       color_q;

  // Per-pixel pipeline.
  logic [1:0]           k_sel;
  logic [3:0]           mask_rest;
  logic [CW-1:0]        col_sel, row_sel;
  logic [WW-1:0]        wx_sel, wy_sel;
  logic [MAW-1:0]       addr_calc;
  logic [MAW-1:0]       addr_q;
  logic [CW-1:0]        col_q, row_q;
  logic                 last_q;
  logic [W2W-1:0]       w_q;
  logic [AW-1:0]        a_q;
  aapb_pkg::rgb_t       old_q;
  aapb_pkg::rgb_t       mix_rgb;
  logic                 out_free;

  // Memory port.
  logic                 mem_we;
  logic [MAW-1:0]       mem_addr;
  logic [23:0]          mem_wdata;
  logic [23:0]          mem_rdata;

  assign bg_write  = cfg_we_i && (cfg_index_i == aapb_pkg::CFG_BG_COLOR);
  assign in_accept = in_valid_i && (state_q == aapb_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Neighbor geometry straight off the input beat.
  always_comb begin
    fx    = in_data_i.x_pos[FRAC_BITS-1:0];
    fy    = in_data_i.y_pos[FRAC_BITS-1:0];
    fx_nz = |fx;
    fy_nz = |fy;
    ax0   = {1'b0, in_data_i.x_pos[PW-1:FRAC_BITS]};
    ay0   = {1'b0, in_data_i.y_pos[PW-1:FRAC_BITS]};
    ax1   = ax0 + CW'(fx_nz);
    ay1   = ay0 + CW'(fy_nz);
    awx0  = ONE - {1'b0, fx};
    awy0  = ONE - {1'b0, fy};
    awx1  = fx_nz ? {1'b0, fx} : ONE;
    awy1  = fy_nz ? {1'b0, fy} : ONE;
    x_sum = {1'b0, in_data_i.x_pos} + HALF;
    y_sum = {1'b0, in_data_i.y_pos} + HALF;
    rx    = x_sum[PW:FRAC_BITS];
    ry    = y_sum[PW:FRAC_BITS];
    alpha_sat = (in_data_i.alpha > 9'd256) ? 9'd256 : in_data_i.alpha;
    if (aa_en_q) begin
      mask_in[0] = in_view(ax0, disp_w_q, CMPW'(MAX_WIDTH)) &&
                   in_view(ay0, disp_h_q, CMPW'(MAX_HEIGHT));
      mask_in[1] = in_view(ax0, disp_w_q, CMPW'(MAX_WIDTH)) &&
                   in_view(ay1, disp_h_q, CMPW'(MAX_HEIGHT));
      mask_in[2] = in_view(ax1, disp_w_q, CMPW'(MAX_WIDTH)) &&
                   in_view(ay0, disp_h_q, CMPW'(MAX_HEIGHT));
      mask_in[3] = in_view(ax1, disp_w_q, CMPW'(MAX_WIDTH)) &&
                   in_view(ay1, disp_h_q, CMPW'(MAX_HEIGHT));
    end else begin
      mask_in = {3'b000, in_view(rx, disp_w_q, CMPW'(MAX_WIDTH)) &&
                         in_view(ry, disp_h_q, CMPW'(MAX_HEIGHT))};
    end
  end

  // Pick the next visible neighbor; the mask tells ahead whether it is the last.
  always_comb begin
    if (mask_q[0]) begin
      k_sel = 2'd0;
    end else if (mask_q[1]) begin
      k_sel = 2'd1;
    end else if (mask_q[2]) begin
      k_sel = 2'd2;
    end else begin
      k_sel = 2'd3;
    end
    mask_rest = mask_q & ~(4'b0001 << k_sel);
    col_sel   = k_sel[1] ? x1_q : x0_q;
    row_sel   = k_sel[0] ? y1_q : y0_q;
    wx_sel    = k_sel[1] ? wx1_q : wx0_q;
    wy_sel    = k_sel[0] ? wy1_q : wy0_q;
    addr_calc = MAW'(row_sel) * MAW'(MAX_WIDTH) + MAW'(col_sel);
  end

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = mix_rgb;
    unique case (state_q)
      aapb_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_cnt_q;
        mem_wdata = bg_q;
        if (fill_cnt_q == LAST_ADDR) begin
          state_d = aapb_pkg::ST_IDLE;
        end
      end
      aapb_pkg::ST_IDLE: begin
        if (in_accept && (mask_in != 4'b0000)) begin
          state_d = aapb_pkg::ST_ADDR;
        end
      end
      aapb_pkg::ST_ADDR: begin
        mem_addr = addr_calc;
        state_d  = aapb_pkg::ST_READ;
      end
      aapb_pkg::ST_READ: begin
        state_d = aapb_pkg::ST_BLEND;
      end
      aapb_pkg::ST_BLEND: begin
        if (out_free) begin
          mem_we  = 1'b1;
          state_d = (mask_q == 4'b0000) ? aapb_pkg::ST_IDLE : aapb_pkg::ST_ADDR;
        end
      end
      default: begin
        state_d = aapb_pkg::ST_IDLE;
      end
    endcase
    if (bg_write) begin
      state_d = aapb_pkg::ST_FILL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aapb_pkg::ST_FILL;
      fill_cnt_q  <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      aa_en_q     <= 1'b1;
      disp_w_q    <= 9'd256;
      disp_h_q    <= 9'd256;
      bg_q        <= '0;
    end else begin
      state_q <= state_d;
      if (bg_write) begin
        fill_cnt_q <= '0;
      end else if (state_q == aapb_pkg::ST_FILL) begin
        fill_cnt_q <= fill_cnt_q + MAW'(1);
      end
      if (in_accept) begin
        mask_q <= mask_in;
      end else if (state_q == aapb_pkg::ST_ADDR) begin
        mask_q <= mask_rest;
      end
      if ((state_q == aapb_pkg::ST_BLEND) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          aapb_pkg::CFG_ANTIALIAS: aa_en_q  <= cfg_wdata_i[0];
          aapb_pkg::CFG_WIDTH:     disp_w_q <= cfg_wdata_i[8:0];
          aapb_pkg::CFG_HEIGHT:    disp_h_q <= cfg_wdata_i[8:0];
          aapb_pkg::CFG_BG_COLOR:  bg_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      alpha_q <= alpha_sat;
      color_q <= {in_data_i.red, in_data_i.green, in_data_i.blue};
      if (aa_en_q) begin
        x0_q  <= ax0;
        x1_q  <= ax1;
        y0_q  <= ay0;
        y1_q  <= ay1;
        wx0_q <= awx0;
        wx1_q <= awx1;
        wy0_q <= awy0;
        wy1_q <= awy1;
      end else begin
        // Nearest mode uses the first neighbor slot only, at full weight.
        x0_q  <= rx;
        x1_q  <= rx;
        y0_q  <= ry;
        y1_q  <= ry;
        wx0_q <= ONE;
        wx1_q <= ONE;
        wy0_q <= ONE;
        wy1_q <= ONE;
      end
    end
    if (state_q == aapb_pkg::ST_ADDR) begin
      addr_q <= addr_calc;
      col_q  <= col_sel;
      row_q  <= row_sel;
      last_q <= (mask_rest == 4'b0000);
      w_q    <= W2W'(wx_sel) * W2W'(wy_sel);
    end
    if (state_q == aapb_pkg::ST_READ) begin
      a_q   <= AW'(w_q) * AW'(alpha_q);
      old_q <= mem_rdata;
    end
    if ((state_q == aapb_pkg::ST_BLEND) && out_free) begin
      out_q.pix_x     <= 8'(col_q);
      out_q.pix_y     <= 8'(row_q);
      out_q.out_red   <= mix_rgb[2];
      out_q.out_green <= mix_rgb[1];
      out_q.out_blue  <= mix_rgb[0];
      out_q.last      <= last_q;
    end
  end

  aapb_mix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mix (
    .a_i     (a_q),
    .color_i (color_q),
    .old_i   (old_q),
    .rgb_o   (mix_rgb)
  );

  aapb_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o  = (state_q != aapb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/aapb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module aapb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/aapb_mix.sv @@
// ----------------------------------------------------------------------------
// Channel mixer
// Blends the drawing color over the stored color on all three channels,
// new = (a*c + (full - a)*old) >> shift, truncated.
// ----------------------------------------------------------------------------
module aapb_mix #(
  parameter int FRAC_BITS = 4
) (
  input  logic [2*FRAC_BITS+8:0] a_i,
  input  aapb_pkg::rgb_t         color_i,
  input  aapb_pkg::rgb_t         old_i,
  output aapb_pkg::rgb_t         rgb_o
);

  localparam int SH = 2 * FRAC_BITS + 8;
  localparam int AW = SH + 1;
  localparam int PW = AW + 8;
  localparam logic [AW-1:0] FULL = {1'b1, {SH{1'b0}}};

  logic [AW-1:0] inv_a;

  // The opacity never exceeds full scale, so the complement stays non-negative.
  assign inv_a = FULL - a_i;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [PW-1:0] sum;
    assign sum = (PW'(a_i) * PW'(color_i[ch])) + (PW'(inv_a) * PW'(old_i[ch]));
    assign rgb_o[ch] = sum[SH+7:SH];
  end

endmodule
